@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Active in simulation; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFA_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define SFA_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SFA_ASSERT_IMP(label, clk, rst_n, a, c)
`define SFA_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/core/sfa_pkg.sv @@
// Shared types and codes for the segment fit allocator.
// No dependencies.
`default_nettype none
package sfa_pkg;
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FIRST = 2'd1,
    OP_BEST  = 2'd2,
    OP_WORST = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ZERO   = 2'd3
  } status_t;

  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned OUT_INDEX_BITS = 6;
  localparam int unsigned OUT_COUNT_BITS = 7;
endpackage
`default_nettype wire

@@ rtl/core/sfa_ram.sv @@
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module sfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/sfa_ctrl.sv @@
// Allocator sequencer: scan, shift and write back through one RAM write port.
// Depends on sfa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sfa_ctrl #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned SIZE_BITS = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [SIZE_BITS-1:0]          in_request_size,
  input  wire logic                          in_load_used,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sfa_pkg::STATUS_BITS-1:0]    out_status,
  output logic [sfa_pkg::OUT_INDEX_BITS-1:0] out_segment_index,
  output logic [SIZE_BITS-1:0]               out_remaining_free,
  output logic [sfa_pkg::OUT_COUNT_BITS-1:0] out_segment_count,
  output logic                               mem_we,
  output logic [$clog2(MAX_SEGMENTS)-1:0]    mem_waddr,
  output logic [SIZE_BITS:0]                 mem_wdata,
  output logic [$clog2(MAX_SEGMENTS)-1:0]    mem_raddr,
  input  wire logic [SIZE_BITS:0]            mem_rdata
);
  import sfa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_TAIL, S_SHIFT, S_PIECE, S_DONE
  } state_t;

  state_t                 state_r;
  logic [CW-1:0]          count_r;
  op_t                    op_r;
  logic [SIZE_BITS-1:0]   req_r;
  logic [CW-1:0]          ptr_r;      // read address issued
  logic                   rd_v_r;     // a read is in flight
  logic [AW-1:0]          rd_a_r;     // address of the in-flight read
  logic                   found_r;
  logic [AW-1:0]          sel_r;
  logic [SIZE_BITS-1:0]   sel_sz_r;
  logic [AW-1:0]          sh_r;       // destination of the next shift write
  logic                   res_v_r;
  logic [1:0]             res_st_r;
  logic [AW-1:0]          res_idx_r;
  logic [SIZE_BITS-1:0]   res_rem_r;

  logic [SIZE_BITS-1:0] rd_sz;
  logic                 rd_used, fits, take;
  assign rd_sz   = mem_rdata[SIZE_BITS-1:0];
  assign rd_used = mem_rdata[SIZE_BITS];
  assign fits    = rd_v_r && !rd_used && (rd_sz >= req_r);
  always_comb begin
    take = 1'b0;
    if (fits) begin
      case (op_r)
        OP_BEST:  take = !found_r || (rd_sz <= sel_sz_r);
        OP_WORST: take = !found_r || (rd_sz > sel_sz_r);
        default:  take = !found_r;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE) && !res_v_r;
  assign out_valid = res_v_r;
  assign out_status = res_st_r;
  assign out_segment_index = OUT_INDEX_BITS'(res_idx_r);
  assign out_remaining_free = res_rem_r;
  assign out_segment_count = OUT_COUNT_BITS'(count_r);

  logic [CW-1:0] sel_ext;
  assign sel_ext = CW'(sel_r);

  // Memory port drive.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sh_r;
    mem_wdata = {rd_used, rd_sz};
    mem_raddr = ptr_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        mem_we    = in_valid && in_ready && (in_operation == OP_LOAD) &&
                    (in_request_size != '0) && (count_r < CW'(MAX_SEGMENTS));
        mem_waddr = count_r[AW-1:0];
        mem_wdata = {in_load_used, in_request_size};
      end
      S_TAIL, S_SHIFT: mem_we = rd_v_r;
      S_PIECE: begin
        mem_we    = 1'b1;
        mem_waddr = sh_r;
        mem_wdata = (sh_r == sel_r) ? {1'b1, req_r} : {1'b0, sel_sz_r - req_r};
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      res_v_r <= 1'b0;
      rd_v_r  <= 1'b0;
    end else begin
      if (res_v_r && out_ready) res_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          rd_v_r <= 1'b0;
          if (in_valid && in_ready) begin
            op_r    <= op_t'(in_operation);
            req_r   <= in_request_size;
            found_r <= 1'b0;
            res_rem_r <= '0;
            if (in_request_size == '0) begin
              res_st_r <= ST_ZERO; res_idx_r <= '0; res_v_r <= 1'b1;
            end else if (in_operation == OP_LOAD) begin
              res_v_r <= 1'b1;
              if (count_r >= CW'(MAX_SEGMENTS)) begin
                res_st_r  <= ST_FULL;
                res_idx_r <= '0;
              end else begin
                res_st_r  <= ST_OK;
                res_idx_r <= count_r[AW-1:0];
                count_r   <= count_r + 1'b1;
              end
            end else begin
              res_idx_r <= '0;
              ptr_r   <= '0;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue one read per cycle; evaluate the previous one.
          if (take) begin
            found_r <= 1'b1; sel_r <= rd_a_r; sel_sz_r <= rd_sz;
          end
          if (ptr_r < count_r && !(op_r == OP_FIRST && (take || found_r))) begin
            rd_v_r <= 1'b1; rd_a_r <= ptr_r[AW-1:0]; ptr_r <= ptr_r + 1'b1;
          end else begin
            rd_v_r  <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          res_rem_r <= '0;
          if (!found_r) begin
            res_v_r <= 1'b1; res_idx_r <= '0;
            res_st_r <= ST_NOFIT; state_r <= S_IDLE;
          end else if (sel_sz_r == req_r) begin
            res_st_r <= ST_OK; res_idx_r <= sel_r;
            state_r <= S_PIECE; sh_r <= sel_r;
          end else if (count_r >= CW'(MAX_SEGMENTS)) begin
            res_v_r <= 1'b1; res_idx_r <= '0;
            res_st_r <= ST_FULL; state_r <= S_IDLE;
          end else begin
            // Shift from the top: read count-1, write count.
            ptr_r   <= count_r - 1'b1;
            sh_r    <= count_r[AW-1:0];
            state_r <= (count_r - 1'b1 > sel_ext) ? S_TAIL : S_PIECE;
          end
        end
        S_TAIL: begin
          // Prime the read pipe, then move one entry per cycle.
          rd_v_r <= 1'b1;
          ptr_r  <= ptr_r - 1'b1;
          state_r <= S_SHIFT;
        end
        S_SHIFT: begin
          if (rd_v_r) sh_r <= sh_r - 1'b1;
          if (ptr_r > sel_ext) begin
            rd_v_r <= 1'b1; ptr_r <= ptr_r - 1'b1;
          end else begin
            rd_v_r <= 1'b0;
            state_r <= S_PIECE;
          end
        end
        S_PIECE: begin
          // Writes sel_r+1 (remainder) then sel_r (used piece); exact fit
          // writes only sel_r.
          if (sh_r == sel_r) begin
            res_v_r   <= 1'b1;
            res_st_r  <= ST_OK;
            res_idx_r <= sel_r;
            state_r   <= S_IDLE;
            if (sel_sz_r != req_r) begin
              res_rem_r <= sel_sz_r - req_r;
              count_r   <= count_r + 1'b1;
            end
          end else begin
            sh_r <= sh_r - 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SFA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(MAX_SEGMENTS))
  `SFA_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE)
  `SFA_ASSERT_IMP(a_err_index, clk, rst_n, res_v_r && res_st_r != ST_OK, res_idx_r == '0)
  `SFA_ASSERT_NXT(a_busy_after, clk, rst_n,
    in_valid && in_ready && in_request_size != '0 && in_operation != OP_LOAD,
    !in_ready)
endmodule
`default_nettype wire

@@ rtl/core/segment_fit_allocator.sv @@
// Top level of the segment fit allocator: control sequencer plus segment RAM.
// Depends on sfa_pkg, sfa_ctrl and sfa_ram.
//
//   channel  direction  fields
//   in_      input      operation, request_size, load_used
//   out_     output     status, segment_index, remaining_free, segment_count
//
// A load or a zero-size request is answered in the cycle after it is accepted.
// An allocation scans the table one entry per cycle, and a split then moves
// every later entry up by one, one per cycle, through the single write port.
// Reset empties the table by clearing the entry count; the RAM is not cleared.
// A waiting result holds the block; in_ready stays low until it is taken.
`default_nettype none
module segment_fit_allocator #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned SIZE_BITS = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [SIZE_BITS-1:0]          in_request_size,
  input  wire logic                          in_load_used,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sfa_pkg::STATUS_BITS-1:0]    out_status,
  output logic [sfa_pkg::OUT_INDEX_BITS-1:0] out_segment_index,
  output logic [SIZE_BITS-1:0]               out_remaining_free,
  output logic [sfa_pkg::OUT_COUNT_BITS-1:0] out_segment_count
);
  import sfa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [SIZE_BITS:0]   mem_wdata, mem_rdata;

  // Each entry stores {used, size}.
  sfa_ram #(.WIDTH(SIZE_BITS + 1), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  sfa_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS), .SIZE_BITS(SIZE_BITS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_request_size(in_request_size),
    .in_load_used(in_load_used),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_segment_index(out_segment_index),
    .out_remaining_free(out_remaining_free), .out_segment_count(out_segment_count),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr), .mem_rdata(mem_rdata)
  );
endmodule
`default_nettype wire
